// ===== design/rbf_pkg.sv =====
// Shared constants and types for the RGBA5551 2x2 box filter.
// Used by rbf_line_buf, rbf_mean and the top level rgba5551_box_filter_2x2.
// No dependencies.
package rbf_pkg;

    // Default frame geometry.
    localparam int FRAME_WIDTH_DEF  = 320;
    localparam int FRAME_HEIGHT_DEF = 240;

    // Pixel format: red 15-11, green 10-6, blue 5-1, alpha 0.
    localparam int PIXEL_W   = 16;
    localparam int CHAN_W    = 5;
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 6;
    localparam int BLUE_LSB  = 1;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    // Result position fields.
    localparam int ROW_OUT_W = 8;
    localparam int COL_OUT_W = 9;

    // Output tdata: out_row, out_col, out_pixel, padded to whole bytes.
    localparam int OUT_FIELDS_W = ROW_OUT_W + COL_OUT_W + PIXEL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_COLS = 1'd1;

endpackage

// ===== design/rbf_line_buf.sv =====
// Line buffer holding the previous row of pixels, one entry per column.
// Depends on rbf_pkg for the pixel type.
// Read-before-write at a single shared address; read data is registered.
module rbf_line_buf #(
    parameter int DEPTH  = rbf_pkg::FRAME_WIDTH_DEF,
    parameter int ADDR_W = $clog2(rbf_pkg::FRAME_WIDTH_DEF)
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [ADDR_W-1:0]    addr,
    input  rbf_pkg::pixel_t      wdata,
    output rbf_pkg::pixel_t      rdata
);

    rbf_pkg::pixel_t mem [DEPTH];
    rbf_pkg::pixel_t rdata_reg;

    // The old entry is read out while the new pixel replaces it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rbf_mean.sv =====
// Per-channel truncated mean of four RGBA5551 pixels, alpha forced to zero.
// Depends on rbf_pkg for the pixel layout.
// Purely combinational; sits between the input stage and the result register.
module rbf_mean (
    input  rbf_pkg::pixel_t  upper_left,
    input  rbf_pkg::pixel_t  above,
    input  rbf_pkg::pixel_t  left,
    input  rbf_pkg::pixel_t  current,
    output rbf_pkg::pixel_t  avg
);

    localparam int SUM_W = rbf_pkg::CHAN_W + 2;

    function automatic rbf_pkg::chan_t chan_mean(
        input rbf_pkg::pixel_t a,
        input rbf_pkg::pixel_t b,
        input rbf_pkg::pixel_t c,
        input rbf_pkg::pixel_t d,
        input int              lsb
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a[lsb +: rbf_pkg::CHAN_W]) + SUM_W'(b[lsb +: rbf_pkg::CHAN_W])
            + SUM_W'(c[lsb +: rbf_pkg::CHAN_W]) + SUM_W'(d[lsb +: rbf_pkg::CHAN_W]);
        return sum[SUM_W-1:2];
    endfunction

    rbf_pkg::chan_t red_mean;
    rbf_pkg::chan_t green_mean;
    rbf_pkg::chan_t blue_mean;

    // Each color channel is averaged on its own; the sum is divided by four.
    always_comb
    begin
        red_mean   = chan_mean(upper_left, above, left, current, rbf_pkg::RED_LSB);
        green_mean = chan_mean(upper_left, above, left, current, rbf_pkg::GREEN_LSB);
        blue_mean  = chan_mean(upper_left, above, left, current, rbf_pkg::BLUE_LSB);
    end

    assign avg = {red_mean, green_mean, blue_mean, 1'b0};

endmodule

// ===== design/rgba5551_box_filter_2x2.sv =====
// Streaming 2x2 box filter over RGBA5551 frames in raster order.
// Pixels enter on the s_axis channel (tdata = pixel, tuser = frame start
// flag, which forces the pixel to position (0,0)). Without a frame start the
// position wraps to (0,0) after the last pixel of a frame.
// When the pixel at (r,c) arrives with r>=1, c>=1, r-1 < region_rows and
// c-1 < region_cols, one result for (r-1,c-1) leaves on m_axis: the
// truncated mean of the 2x2 block per color channel, alpha zero, with its
// row and column. Other pixels produce no transfer on m_axis.
// Throughput is one pixel per clock while the receiver does not stall. A pixel
// first sits in the input stage, where the line buffer is read, and its
// result is then held in the result register, which drives m_axis_tvalid.
// If the receiver stalls, the result register holds its transfer and the
// input stage still takes pixels until it holds one that produces a result;
// s_axis_tready then drops until the result moves on. A pixel that produces
// no result never waits in the input stage.
// Reset clears the position counters, the region registers, the neighbor
// pixels and all valid flags; the line buffer is not cleared, and every
// entry is written in row 0 before it is read. The user must write the region
// registers through cfg_we/cfg_index/cfg_data only while idle; the block
// does not enforce this. Depends on rbf_pkg, rbf_line_buf and rbf_mean.
module rgba5551_box_filter_2x2 #(
    parameter int FRAME_WIDTH  = rbf_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = rbf_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [rbf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbf_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rbf_pkg::PIXEL_W-1:0]         s_axis_tdata,   // [15:0] pixel_in
    input  logic                                s_axis_tuser,   // [0] frame_start

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] out_row, [16:8] out_col, [32:17] out_pixel, [39:33] zero
    output logic [rbf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int COL_W  = $clog2(FRAME_WIDTH);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT);
    localparam int RCMP_W = (ROW_W > rbf_pkg::ROW_OUT_W) ? ROW_W : rbf_pkg::ROW_OUT_W;
    localparam int CCMP_W = (COL_W > rbf_pkg::COL_OUT_W) ? COL_W : rbf_pkg::COL_OUT_W;
    localparam int PAD_W  = rbf_pkg::OUT_TDATA_W - rbf_pkg::OUT_FIELDS_W;

    // Configuration registers.
    logic [rbf_pkg::ROW_OUT_W-1:0] region_rows_reg;
    logic [rbf_pkg::COL_OUT_W-1:0] region_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_rows_reg <= '0;
            region_cols_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbf_pkg::REG_REGION_ROWS: region_rows_reg <= cfg_data[rbf_pkg::ROW_OUT_W-1:0];
                rbf_pkg::REG_REGION_COLS: region_cols_reg <= cfg_data[rbf_pkg::COL_OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Position of the incoming pixel and the position of the one after it.
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next, pos_row;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next, pos_col;
    logic             last_col, last_row;
    logic             in_fire;

    assign in_fire = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        pos_row  = s_axis_tuser ? '0 : row_cnt_reg;
        pos_col  = s_axis_tuser ? '0 : col_cnt_reg;
        last_col = (pos_col == COL_W'(FRAME_WIDTH - 1));
        last_row = (pos_row == ROW_W'(FRAME_HEIGHT - 1));
        col_cnt_next = last_col ? '0 : pos_col + 1'b1;
        if (!last_col)
            row_cnt_next = pos_row;
        else if (last_row)
            row_cnt_next = '0;
        else
            row_cnt_next = pos_row + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // Line buffer: the pixel above is read as the new pixel is stored.
    rbf_pkg::pixel_t above;

    rbf_line_buf #(
        .DEPTH  (FRAME_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .clk    (clk),
        .en     (in_fire),
        .addr   (pos_col),
        .wdata  (s_axis_tdata),
        .rdata  (above)
    );

    // Input stage.
    logic             s1_valid_reg;
    rbf_pkg::pixel_t  s1_pixel_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;

    logic              s1_emit, s1_adv, out_free;
    logic [RCMP_W-1:0] s1_row_ext;
    logic [CCMP_W-1:0] s1_col_ext;

    always_comb
    begin
        s1_row_ext = RCMP_W'(s1_row_reg);
        s1_col_ext = CCMP_W'(s1_col_reg);
        // r-1 < region_rows is r <= region_rows once r is at least one.
        s1_emit = (s1_row_reg != '0) && (s1_col_reg != '0)
               && (s1_row_ext <= RCMP_W'(region_rows_reg))
               && (s1_col_ext <= CCMP_W'(region_cols_reg));
        out_free = !m_axis_tvalid || m_axis_tready;
        s1_adv   = s1_valid_reg && (!s1_emit || out_free);
    end

    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg <= s_axis_tdata;
            s1_row_reg   <= pos_row;
            s1_col_reg   <= pos_col;
        end
    end

    // Neighbors on the left, advanced as each pixel leaves the input stage.
    rbf_pkg::pixel_t upper_left_reg;
    rbf_pkg::pixel_t left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_left_reg <= '0;
            left_reg       <= '0;
        end
        else if (s1_adv)
        begin
            upper_left_reg <= above;
            left_reg       <= s1_pixel_reg;
        end
    end

    // Averaging of the 2x2 block.
    rbf_pkg::pixel_t avg;

    rbf_mean u_mean (
        .upper_left (upper_left_reg),
        .above      (above),
        .left       (left_reg),
        .current    (s1_pixel_reg),
        .avg        (avg)
    );

    // Result register.
    logic                          out_valid_reg;
    logic [rbf_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic [rbf_pkg::COL_OUT_W-1:0] out_col_reg;
    rbf_pkg::pixel_t               out_pixel_reg;
    logic [RCMP_W-1:0]             row_m1;
    logic [CCMP_W-1:0]             col_m1;
    logic                          out_load;

    always_comb
    begin
        row_m1   = s1_row_ext - 1'b1;
        col_m1   = s1_col_ext - 1'b1;
        out_load = s1_adv && s1_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= row_m1[rbf_pkg::ROW_OUT_W-1:0];
            out_col_reg   <= col_m1[rbf_pkg::COL_OUT_W-1:0];
            out_pixel_reg <= avg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_pixel_reg, out_col_reg, out_row_reg};

endmodule

// ===== tb/rgba5551_box_filter_2x2_test.sv =====
// Self-checking testbench for rgba5551_box_filter_2x2: streams RGBA5551 frames and checks
// every averaged pixel against a behavioral model of the 2x2 box filter kept in this file.
// Depends on rbf_pkg and the rgba5551_box_filter_2x2 RTL.
module rgba5551_box_filter_2x2_test;

    localparam int FRAME_W       = rbf_pkg::FRAME_WIDTH_DEF;
    localparam int FRAME_H       = rbf_pkg::FRAME_HEIGHT_DEF;
    localparam int RANDOM_ITEMS  = 560;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_MAX      = 14;

    // One pixel transfer waiting to be sent.
    typedef struct packed {
        rbf_pkg::pixel_t pixel;
        logic            frame_start;
    } pixel_xfer_t;

    // One averaged pixel as the block should report it.
    typedef struct packed {
        logic [rbf_pkg::ROW_OUT_W-1:0] row;
        logic [rbf_pkg::COL_OUT_W-1:0] col;
        rbf_pkg::pixel_t               pixel;
    } box_average_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [rbf_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [rbf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rbf_pkg::PIXEL_W-1:0]     s_axis_tdata = '0;    // [15:0] pixel_in
    logic                            s_axis_tuser = 1'b0;  // [0] frame_start
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [7:0] row, [16:8] col, [32:17] pixel
    logic [rbf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Stimulus and expectation stores.
    pixel_xfer_t  pending_pixels[$];
    box_average_t expected_averages[$];
    int           error_count = 0;

    // Model state of the filter.
    rbf_pkg::pixel_t line_mem [FRAME_W] = '{default: '0};
    rbf_pkg::pixel_t left_px = '0;
    rbf_pkg::pixel_t upleft_px = '0;
    int              row_pos = 0;
    int              col_pos = 0;
    int unsigned     region_rows_cfg = 0;
    int unsigned     region_cols_cfg = 0;

    // Handshake bookkeeping shared between the clocked processes.
    bit pixel_taken = 1'b0;
    bit send_busy = 1'b0;
    int send_gap = 0;
    int send_idle_max = IDLE_MAX;
    bit result_taken = 1'b0;
    int sink_wait = 0;
    int sink_hold = 0;
    int recv_stall_max = IDLE_MAX;

    rgba5551_box_filter_2x2 #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Truncated mean of one 5-bit channel over four pixels.
    function automatic rbf_pkg::chan_t chan_mean4(rbf_pkg::pixel_t a, rbf_pkg::pixel_t b,
                                                  rbf_pkg::pixel_t c, rbf_pkg::pixel_t d,
                                                  int lsb);
        logic [rbf_pkg::CHAN_W+1:0] sum;
        sum = {2'b00, a[lsb +: rbf_pkg::CHAN_W]} + {2'b00, b[lsb +: rbf_pkg::CHAN_W]}
            + {2'b00, c[lsb +: rbf_pkg::CHAN_W]} + {2'b00, d[lsb +: rbf_pkg::CHAN_W]};
        return sum[rbf_pkg::CHAN_W+1:2];
    endfunction

    // Advances the filter model by one pixel and queues the averaged pixel it yields, if any.
    task automatic predict_box_average(input rbf_pkg::pixel_t px, input logic frame_start);
        rbf_pkg::pixel_t above;
        box_average_t    avg;
        if (frame_start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        above = line_mem[col_pos];
        if (row_pos >= 1 && col_pos >= 1 && row_pos - 1 < region_rows_cfg
            && col_pos - 1 < region_cols_cfg)
        begin
            avg.row   = rbf_pkg::ROW_OUT_W'(row_pos - 1);
            avg.col   = rbf_pkg::COL_OUT_W'(col_pos - 1);
            avg.pixel = {chan_mean4(upleft_px, above, left_px, px, rbf_pkg::RED_LSB),
                         chan_mean4(upleft_px, above, left_px, px, rbf_pkg::GREEN_LSB),
                         chan_mean4(upleft_px, above, left_px, px, rbf_pkg::BLUE_LSB),
                         1'b0};
            expected_averages.push_back(avg);
        end
        upleft_px = above;
        line_mem[col_pos] = px;
        left_px = px;
        col_pos++;
        if (col_pos >= FRAME_W)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= FRAME_H)
                row_pos = 0;
        end
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endfunction

    // Checks each result transfer and feeds each accepted pixel to the model.
    always @(posedge clk)
    begin : scoreboard
        box_average_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_taken = 1'b1;
                if (expected_averages.size() == 0)
                begin
                    error_count++;
                    $error("unexpected result transfer, tdata 0x%0h", m_axis_tdata);
                end
                else
                begin
                    want = expected_averages.pop_front();
                    check_field("out_row", 32'(want.row),
                                32'(m_axis_tdata[rbf_pkg::ROW_OUT_W-1:0]));
                    check_field("out_col", 32'(want.col),
                                32'(m_axis_tdata[rbf_pkg::ROW_OUT_W +: rbf_pkg::COL_OUT_W]));
                    check_field("out_pixel", 32'(want.pixel),
                                32'(m_axis_tdata[rbf_pkg::ROW_OUT_W + rbf_pkg::COL_OUT_W +:
                                                 rbf_pkg::PIXEL_W]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pixel_taken = 1'b1;
                predict_box_average(s_axis_tdata, s_axis_tuser);
            end
        end
    end

    // Pixel sender: holds each pixel until its transfer, then idles for a drawn gap.
    always @(negedge clk)
    begin : driver
        pixel_xfer_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!send_busy || pixel_taken)
        begin
            pixel_taken = 1'b0;
            send_busy = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                nxt = pending_pixels.pop_front();
                s_axis_tdata  <= nxt.pixel;
                s_axis_tuser  <= nxt.frame_start;
                s_axis_tvalid <= 1'b1;
                send_busy = 1'b1;
                send_gap = (send_idle_max == 0) ? 0 : $urandom_range(0, send_idle_max);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver: stalls for a drawn number of cycles after each transfer,
    // and for a long hold-off when one is requested.
    always @(negedge clk)
    begin : receiver
        if (result_taken)
        begin
            result_taken = 1'b0;
            sink_wait = (recv_stall_max == 0) ? 0 : $urandom_range(0, recv_stall_max);
        end
        if (sink_hold > 0)
        begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_wait > 0)
        begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic queue_pixel(input rbf_pkg::pixel_t px, input logic frame_start);
        pending_pixels.push_back('{pixel: px, frame_start: frame_start});
    endtask

    // Waits until every pixel is sent, every result has arrived and the pipeline is empty.
    task automatic drain_block();
        while (pending_pixels.size() > 0 || send_busy)
            @(negedge clk);
        while (expected_averages.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes one region register; the model takes the value as the register keeps it.
    task automatic write_region(input logic [rbf_pkg::CFG_IDX_W-1:0] idx,
                                input int unsigned value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[rbf_pkg::CFG_DATA_W-1:0];
        if (idx == rbf_pkg::REG_REGION_ROWS)
            region_rows_cfg = value[rbf_pkg::ROW_OUT_W-1:0];
        else
            region_cols_cfg = value[rbf_pkg::COL_OUT_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        rbf_pkg::pixel_t px;
        int unsigned     rows;
        int unsigned     cols;
        int              len;
        int              random_items;
        bit              noisy;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Regions are empty after reset, so these pixels give no results.
        for (int i = 0; i < 40; i++)
            queue_pixel(16'($urandom), 1'b0);
        drain_block();

        // Directed frame: full-scale and all-zero blocks, carries in the sums,
        // the clipped last column, and a frame start in the middle of a row.
        write_region(rbf_pkg::REG_REGION_ROWS, FRAME_H - 1);
        write_region(rbf_pkg::REG_REGION_COLS, FRAME_W - 1);
        for (int i = 0; i < 2 * FRAME_W + 6; i++)
        begin
            case (i)
                0, 1, FRAME_W, FRAME_W + 1:         px = 16'hFFFF;
                2, 3, FRAME_W + 2, FRAME_W + 3:     px = 16'h0000;
                4, FRAME_W + 5:                     px = 16'h8421;
                5, FRAME_W + 4:                     px = 16'h7BDE;
                default:                            px = 16'($urandom);
            endcase
            queue_pixel(px, i == 0);
        end
        queue_pixel(16'hFFFE, 1'b1);
        queue_pixel(16'h0001, 1'b0);
        drain_block();

        // Back-pressure: a long receiver hold-off while pixels keep coming,
        // then a sender pause in the middle of the frame until all results are in.
        send_idle_max = 0;
        queue_pixel(16'($urandom), 1'b1);
        for (int i = 1; i < FRAME_W + 60; i++)
            queue_pixel(16'($urandom), 1'b0);
        while (expected_averages.size() == 0)
            @(posedge clk);
        sink_hold = 120;
        drain_block();
        for (int i = 0; i < 60; i++)
            queue_pixel(16'($urandom), 1'b0);
        drain_block();

        // Random frames, each under its own region setting.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0:       rows = 0;
                1:       rows = 1;
                2:       rows = FRAME_H - 1;
                3:       rows = $urandom_range(0, (1 << rbf_pkg::CFG_DATA_W) - 1);
                default: rows = $urandom_range(2, FRAME_H - 2);
            endcase
            case ($urandom_range(0, 4))
                0:       cols = 0;
                1:       cols = 1;
                2:       cols = FRAME_W - 1;
                3:       cols = $urandom_range(0, (1 << rbf_pkg::CFG_DATA_W) - 1);
                default: cols = $urandom_range(2, FRAME_W - 2);
            endcase
            write_region(rbf_pkg::REG_REGION_ROWS, rows);
            write_region(rbf_pkg::REG_REGION_COLS, cols);
            send_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;

            // Most frames are well formed; a few carry stray frame starts.
            len = $urandom_range(FRAME_W + 10, FRAME_W + 70);
            noisy = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < len; k++)
            begin
                if (k == 0)
                    queue_pixel(16'($urandom), !noisy || $urandom_range(0, 1) == 1);
                else
                    queue_pixel(16'($urandom), noisy && $urandom_range(0, 39) == 0);
            end
            random_items += len;
            drain_block();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== rgba5551_box_filter_2x2.f =====
design/rbf_pkg.sv
design/rbf_line_buf.sv
design/rbf_mean.sv
design/rgba5551_box_filter_2x2.sv
tb/rgba5551_box_filter_2x2_test.sv
